FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the HSV to RGB converter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the house clock and reset names.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: widths, constants, sector codes, types.
// No dependencies.
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int unsigned HUE_W    = 16;
  localparam int unsigned UNIT_W   = 9;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RGB_W    = 3 * BYTE_W;
  // f*s fits in 24 bits, (1-f)*s needs one more for the full-turn case
  localparam int unsigned FS_W     = FRAC_W + BYTE_W;
  localparam int unsigned GS_W     = FS_W + 1;
  localparam int unsigned PROD_W   = GS_W + BYTE_W;

  localparam logic [UNIT_W-1:0]   UNIT_ONE   = UNIT_W'(256);
  localparam logic [FRAC_W:0]     FRAC_ONE   = (FRAC_W+1)'(65536);
  localparam logic [GS_W-1:0]     FULL_SCALE = GS_W'(1 << FS_W);
  localparam logic [BYTE_W-1:0]   BYTE_MAX   = '1;
  localparam logic [HUE_W+2:0]    SECTORS    = (HUE_W+3)'(6);

  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Per-pixel intermediate components, units of 1/256 (0..256)
  typedef struct packed {
    logic [UNIT_W-1:0] v;
    logic [UNIT_W-1:0] p;
    logic [UNIT_W-1:0] q;
    logic [UNIT_W-1:0] t;
  } comp_t;

endpackage

FILE: hdl/hsv2rgb_in_if.sv
// Input channel of the HSV to RGB converter: valid/ready plus HSV payload.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
interface hsv2rgb_in_if
  import hsv2rgb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [UNIT_W-1:0] saturation;
  logic [UNIT_W-1:0] brightness_value;

  modport source (output valid, output hue, output saturation,
                  output brightness_value, input ready);
  modport sink   (input valid, input hue, input saturation,
                  input brightness_value, output ready);
endinterface

FILE: hdl/hsv2rgb_out_if.sv
// Output channel of the HSV to RGB converter: valid/ready plus packed RGB.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
interface hsv2rgb_out_if
  import hsv2rgb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] rgb_word;

  modport source (output valid, output rgb_word, input ready);
  modport sink   (input valid, input rgb_word, output ready);
endinterface

FILE: hdl/hsv2rgb_place.sv
// Sector placement of v, p, q, t into red, green, blue with byte saturation.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps
module hsv2rgb_place
  import hsv2rgb_pkg::*;
(
  input  logic [SECTOR_W-1:0] sector_i,
  input  comp_t               comp_i,
  output logic [RGB_W-1:0]    rgb_o
);

  logic [UNIT_W-1:0] r, g, b;

  function automatic logic [BYTE_W-1:0] sat_byte(input logic [UNIT_W-1:0] x);
    sat_byte = x[UNIT_W-1] ? BYTE_MAX : x[BYTE_W-1:0];
  endfunction

  always_comb begin
    unique case (sector_e'(sector_i))
      SEC_RED_YEL: begin r = comp_i.v; g = comp_i.t; b = comp_i.p; end
      SEC_YEL_GRN: begin r = comp_i.q; g = comp_i.v; b = comp_i.p; end
      SEC_GRN_CYN: begin r = comp_i.p; g = comp_i.v; b = comp_i.t; end
      SEC_CYN_BLU: begin r = comp_i.p; g = comp_i.q; b = comp_i.v; end
      SEC_BLU_MAG: begin r = comp_i.t; g = comp_i.p; b = comp_i.v; end
      default:     begin r = comp_i.v; g = comp_i.p; b = comp_i.q; end
    endcase
  end

  assign rgb_o = {sat_byte(r), sat_byte(g), sat_byte(b)};

endmodule

FILE: hdl/hsv_to_rgb_converter.sv
// HSV to RGB converter, four-stage pipeline: a transaction passes the stage 1,
// stage 2 and stage 3 registers and then the output register. Throughput one
// transaction per cycle while the output is not stalled. A stall holds each full
// stage whose successor is also held; empty stages still fill. Reset (rst_ni,
// async, active low) clears all stage valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hsv2rgb_in_if.sink    in_i,
  hsv2rgb_out_if.source out_o
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------------------
  // Stage control. Each stage loads when it is empty or its successor moves,
  // so bubbles collapse and a full pipe stalls without losing data.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy   = !out_valid_q || out_o.ready;
  assign s3_rdy    = !s3_valid_q  || out_rdy;
  assign s2_rdy    = !s2_valid_q  || s3_rdy;
  assign s1_rdy    = !s1_valid_q  || s2_rdy;
  assign in_i.ready = s1_rdy;

  // ---------------------------------------------------------------------------
  // Stage 1: clamp s and v to 1.0, hue*6 -> sector and 16-bit fraction f.
  // ---------------------------------------------------------------------------
  logic [HUE_W+2:0]    hue_x6;
  logic [UNIT_W-1:0]   sat_clamp, val_clamp;
  logic [SECTOR_W-1:0] s1_sector_q;
  logic [FRAC_W-1:0]   s1_frac_q;
  logic [UNIT_W-1:0]   s1_sat_q, s1_val_q;

  assign hue_x6    = (HUE_W+3)'(in_i.hue) * SECTORS;
  assign sat_clamp = (in_i.saturation > UNIT_ONE) ? UNIT_ONE : in_i.saturation;
  assign val_clamp = (in_i.brightness_value > UNIT_ONE) ? UNIT_ONE
                                                        : in_i.brightness_value;

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_i.valid) begin
      s1_sector_q <= hue_x6[HUE_W+2:FRAC_W];
      s1_frac_q   <= hue_x6[FRAC_W-1:0];
      s1_sat_q    <= sat_clamp;
      s1_val_q    <= val_clamp;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: f*s, (1-f)*s, and p = floor(v*(1-s)).
  // ---------------------------------------------------------------------------
  logic [FS_W-1:0]     fs_d;
  logic [GS_W-1:0]     gs_d;
  logic [2*UNIT_W-1:0] p_prod;
  logic [SECTOR_W-1:0] s2_sector_q;
  logic [FS_W-1:0]     s2_fs_q;
  logic [GS_W-1:0]     s2_gs_q;
  logic [UNIT_W-1:0]   s2_val_q, s2_p_q;

  assign fs_d   = FS_W'(s1_frac_q) * FS_W'(s1_sat_q);
  assign gs_d   = GS_W'(FRAC_ONE - (FRAC_W+1)'(s1_frac_q)) * GS_W'(s1_sat_q);
  assign p_prod = (2*UNIT_W)'(s1_val_q) * (2*UNIT_W)'(UNIT_ONE - s1_sat_q);

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_valid_q) begin
      s2_sector_q <= s1_sector_q;
      s2_fs_q     <= fs_d;
      s2_gs_q     <= gs_d;
      s2_val_q    <= s1_val_q;
      s2_p_q      <= p_prod[BYTE_W+UNIT_W-1:BYTE_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: q = floor(v*(1-fs)), t = floor(v*(1-(1-f)s)), 2^24 scale.
  // ---------------------------------------------------------------------------
  logic [GS_W-1:0]     q_mult, t_mult;
  logic [PROD_W-1:0]   q_prod, t_prod;
  logic [SECTOR_W-1:0] s3_sector_q;
  comp_t               s3_comp_q;

  assign q_mult = FULL_SCALE - GS_W'(s2_fs_q);
  assign t_mult = FULL_SCALE - s2_gs_q;
  assign q_prod = PROD_W'(s2_val_q) * PROD_W'(q_mult);
  assign t_prod = PROD_W'(s2_val_q) * PROD_W'(t_mult);

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_valid_q) begin
      s3_sector_q <= s2_sector_q;
      s3_comp_q.v <= s2_val_q;
      s3_comp_q.p <= s2_p_q;
      s3_comp_q.q <= q_prod[FS_W+UNIT_W-1:FS_W];
      s3_comp_q.t <= t_prod[FS_W+UNIT_W-1:FS_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sector placement and saturation into the output register.
  // ---------------------------------------------------------------------------
  logic [RGB_W-1:0] rgb_d, rgb_q;

  hsv2rgb_place u_place (
    .sector_i (s3_sector_q),
    .comp_i   (s3_comp_q),
    .rgb_o    (rgb_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_rdy && s3_valid_q) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.rgb_word = rgb_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_q  <= in_i.valid;
      if (s2_rdy)  s2_valid_q  <= s1_valid_q;
      if (s3_rdy)  s3_valid_q  <= s2_valid_q;
      if (out_rdy) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_STD(a_sector_range, s1_valid_q |-> (s1_sector_q <= SECTOR_W'(SEC_MAG_RED)), "sector out of range")
  `ASSERT_STD(a_comp_range, s3_valid_q |-> (s3_comp_q.q <= UNIT_ONE && s3_comp_q.t <= UNIT_ONE && s3_comp_q.p <= UNIT_ONE), "component above 1.0")
  `ASSERT_STD(a_stall_hold, (s3_valid_q && !out_rdy) |=> (s3_valid_q && $stable(s3_comp_q)), "stage 3 lost data in stall")
  `ASSERT_STD(a_full_when_blocked, !in_i.ready |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q), "input blocked with a free stage")

endmodule

FILE: dv/tb_hsv_to_rgb_converter.sv
// Testbench for hsv_to_rgb_converter: directed and random HSV colors, checked
// against a local fixed-point HSV to RGB predictor. Depends on hsv2rgb_pkg,
// hsv2rgb_in_if, hsv2rgb_out_if and the converter RTL.
`timescale 1ns / 1ps
module tb_hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 3;
  localparam int unsigned DRAIN_CYCLES   = 10;   // pipeline is 4 deep, some margin
  localparam int unsigned SINK_HOLD_LEN  = 150;  // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 1000; // cycles with no transaction

  logic clk_i = 1'b0;
  logic rst_ni;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hsv2rgb_in_if  in_ch ();
  hsv2rgb_out_if out_ch ();

  hsv_to_rgb_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Colors we expect to see on the output, oldest first.
  logic [RGB_W-1:0] expected_rgb_q[$];
  int unsigned      mismatch_count = 0;

  // Idle controls for the stimulus and the receiver.
  bit src_idle_on   = 1'b0;
  bit sink_idle_on  = 1'b0;
  bit sink_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Components can reach 256 (1.0); those clip to 255 rather than carrying
  // into the neighboring byte.
  function automatic logic [BYTE_W-1:0] clip_byte(input logic [63:0] x);
    return (x > 64'(BYTE_MAX)) ? BYTE_MAX : x[BYTE_W-1:0];
  endfunction

  // Fixed-point HSV to RGB. Every component is formed exactly as
  // component*256 and truncated toward zero.
  function automatic logic [RGB_W-1:0] hsv_color(input logic [HUE_W-1:0]  hue,
                                                 input logic [UNIT_W-1:0] sat_in,
                                                 input logic [UNIT_W-1:0] val_in);
    logic [63:0] s, v, h6, f, full, cp, cq, ct, r, g, b;
    sector_e     sec;
    // out-of-range saturation / value clamp to 1.0
    s = (sat_in > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(sat_in);
    v = (val_in > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(val_in);
    // hue*6: integer part is the sector, the low 16 bits the fraction f
    h6   = 64'(hue) * 64'(SECTORS);
    sec  = sector_e'(h6[FRAC_W+SECTOR_W-1:FRAC_W]);
    f    = 64'(h6[FRAC_W-1:0]);
    full = 64'(FRAC_ONE) * 64'(UNIT_ONE);
    cp = (v * (64'(UNIT_ONE) - s)) >> BYTE_W;
    cq = (v * (full - f * s)) >> FS_W;
    ct = (v * (full - (64'(FRAC_ONE) - f) * s)) >> FS_W;
    case (sec)
      SEC_RED_YEL: begin r = v;  g = ct; b = cp; end
      SEC_YEL_GRN: begin r = cq; g = v;  b = cp; end
      SEC_GRN_CYN: begin r = cp; g = v;  b = ct; end
      SEC_CYN_BLU: begin r = cp; g = cq; b = v;  end
      SEC_BLU_MAG: begin r = ct; g = cp; b = v;  end
      default:     begin r = v;  g = cp; b = cq; end
    endcase
    return {clip_byte(r), clip_byte(g), clip_byte(b)};
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly short, now and then long.
  function automatic int unsigned pick_idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 3);
    else if (roll < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Saturation / value: mostly in range, with the ends and above-range values
  // weighted up so the clamps and full components get regular hits.
  function automatic logic [UNIT_W-1:0] rand_unit();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return UNIT_ONE;
    else if (roll < 14) return '0;
    else if (roll < 24) return UNIT_W'($urandom_range(257, 511));
    else return UNIT_W'($urandom_range(0, 256));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drives one color and waits for its transaction. With no gap the
  // valid stays high so the next call can go out on the very next edge.
  // ---------------------------------------------------------------------------
  task automatic send_color(input logic [HUE_W-1:0]  hue,
                            input logic [UNIT_W-1:0] sat,
                            input logic [UNIT_W-1:0] val);
    int unsigned gap;
    in_ch.valid            <= 1'b1;
    in_ch.hue              <= hue;
    in_ch.saturation       <= sat;
    in_ch.brightness_value <= val;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_rgb_q.push_back(hsv_color(hue, sat, val));
    gap = (src_idle_on && $urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_colors(input int unsigned count);
    repeat (count) begin
      send_color(HUE_W'($urandom_range(0, 65535)), rand_unit(), rand_unit());
    end
  endtask

  // Drop valid and wait until every expected color has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every sector boundary, clamps and full components.
  task automatic test_directed_extremes();
    logic [HUE_W-1:0] boundary_hue;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_color('0, '0, '0);
    send_color('1, '1, '1);                  // all ones, both fields clamp
    send_color('0, '0, UNIT_ONE);            // white: every component is full
    send_color('0, UNIT_ONE, UNIT_ONE);      // pure red
    send_color(16'h8000, UNIT_ONE, 9'd128);
    // just below and at each sector change, f wraps to near zero
    for (int k = 1; k < 6; k++) begin
      boundary_hue = HUE_W'((k * 65536 + 5) / 6);
      send_color(boundary_hue - 1'b1, UNIT_ONE, UNIT_ONE);
      send_color(boundary_hue, UNIT_ONE, UNIT_ONE);
    end
    send_color(16'h2AAA, 9'd257, 9'd200);    // saturation just above range
    send_color(16'h6000, 9'd100, 9'd257);    // value just above range
    send_color(16'h1234, 9'd1, UNIT_ONE);    // near-full q and t
    send_color(16'hFFFF, UNIT_ONE, 9'd255);
    send_color(16'h5555, 9'h155, 9'h0AA);    // alternating bit patterns
    send_color(16'hAAAA, 9'h0AA, 9'h155);
    drain_results();
  endtask

  // Back-to-back traffic, receiver always ready.
  task automatic test_random_streaming();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_random_colors(200);
  endtask

  // Random gaps on both sides.
  task automatic test_random_idling();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_random_colors(700);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and the input stalls.
  task automatic test_sink_hold_off();
    src_idle_on   = 1'b0;
    sink_idle_on  = 1'b0;
    sink_hold_req = 1'b1;
    send_random_colors(40);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_random_colors(60);
  endtask

  // Bursts with the sender pausing until the pipeline is fully drained.
  task automatic test_drained_bursts();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (4) begin
      send_random_colors(50);
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready with random stalls; a hold-off request forces a long one.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (sink_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_LEN) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        repeat (pick_idle_len()) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transaction is matched against the oldest expected
  // color.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_rgb
    logic [RGB_W-1:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_rgb_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected rgb_word %06h, nothing outstanding",
                 $time, out_ch.rgb_word);
      end else begin
        want = expected_rgb_q.pop_front();
        if (out_ch.rgb_word !== want) begin
          mismatch_count++;
          $display("%0t: rgb_word mismatch: expected %06h, actual %06h",
                   $time, want, out_ch.rgb_word);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side means a hang.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
        $display("** hsv_to_rgb_converter: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                 <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.hue              <= '0;
    in_ch.saturation       <= '0;
    in_ch.brightness_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_streaming();
    test_random_idling();
    test_sink_hold_off();
    test_drained_bursts();

    drain_results();
    // catch any stray result still in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_rgb_q.size() == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule
